>>> hw/rtl/htw_pkg.sv
// Shared constants, types and the slot selection function of the hierarchical timer wheel.
package htw_pkg;

  localparam int TIMER_COUNT  = 64;
  localparam int LEVEL0_BITS  = 8;
  localparam int UPPER_BITS   = 6;
  localparam int UPPER_LEVELS = 4;
  localparam int TICK_BITS    = 32;

  localparam int L0_SIZE    = 1 << LEVEL0_BITS;
  localparam int UP_SIZE    = 1 << UPPER_BITS;
  localparam int SLOT_TOTAL = L0_SIZE + UPPER_LEVELS * UP_SIZE;
  localparam int SLOT_W     = $clog2(SLOT_TOTAL);
  localparam int ID_W       = $clog2(TIMER_COUNT);
  localparam int LINK_W     = $clog2(TIMER_COUNT + 1);
  localparam int CNT_W      = $clog2(TIMER_COUNT + 1);
  localparam int LIDX_W     = (UPPER_LEVELS > 1) ? $clog2(UPPER_LEVELS) : 1;

  localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(TIMER_COUNT);

  // Field widths on the stream ports.
  localparam int OP_W        = 2;
  localparam int TIMER_ID_W  = 6;
  localparam int DEADLINE_W  = 32;
  localparam int WOKEN_W     = 6;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  localparam logic CAUSE_EXPIRED   = 1'b0;
  localparam logic CAUSE_CANCELLED = 1'b1;

  typedef struct packed {
    logic [TICK_BITS-1:0] dl;
    logic [SLOT_W-1:0]    slot;
    logic [ID_W-1:0]      prv;
    logic [ID_W-1:0]      nxt;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [LINK_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
  } head_req_t;

  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] waddr;
    entry_t          wdata;
    logic [ID_W-1:0] raddr;
  } ent_req_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    logic            cause;
    logic            last;
  } emit_t;

  // Slot that a timer with deadline dl belongs in at time now.
  function automatic logic [SLOT_W-1:0] file_slot(input logic [TICK_BITS-1:0] dl,
                                                  input logic [TICK_BITS-1:0] now);
    logic [TICK_BITS-1:0] expv;
    logic [TICK_BITS-1:0] diff;
    logic [SLOT_W-1:0]    s;
    logic                 found;
    int                   lvl;
    int                   sh;
    int                   k;
    expv  = (dl > now) ? dl : now;
    diff  = expv - now;
    lvl   = UPPER_LEVELS;
    found = 1'b0;
    for (k = 0; k < UPPER_LEVELS; k++) begin
      sh = LEVEL0_BITS + k * UPPER_BITS;
      if (!found && ((sh >= TICK_BITS) || ((diff >> sh) == '0))) begin
        lvl   = k;
        found = 1'b1;
      end
    end
    if (lvl == 0) begin
      s = SLOT_W'(expv & TICK_BITS'(L0_SIZE - 1));
    end else begin
      sh = LEVEL0_BITS + (lvl - 1) * UPPER_BITS;
      s  = SLOT_W'(L0_SIZE + (lvl - 1) * UP_SIZE);
      if (sh < TICK_BITS) begin
        s = s + SLOT_W'((expv >> sh) & TICK_BITS'(UP_SIZE - 1));
      end
    end
    return s;
  endfunction

endpackage

>>> hw/rtl/htw_ram.sv
// Generic single write port, single read port RAM with registered read data.
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/htw_ctrl.sv
// Sequencer that walks, links and unlinks timer lists held in the slot and entry memories.
module htw_ctrl import htw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       in_op,
  input  logic [TIMER_ID_W-1:0] in_id,
  input  logic [DEADLINE_W-1:0] in_dl,
  output head_req_t             hreq,
  input  logic [LINK_W-1:0]     hrd,
  output ent_req_t              ereq,
  input  entry_t                erd,
  output emit_t                 emit,
  input  logic                  emit_ok
);

  typedef enum logic [21:0] {
    ST_CLEAR = 22'h000001,
    ST_IDLE  = 22'h000002,
    ST_UL0   = 22'h000004,
    ST_UL1   = 22'h000008,
    ST_UL2   = 22'h000010,
    ST_UL3   = 22'h000020,
    ST_UL4   = 22'h000040,
    ST_FILE  = 22'h000080,
    ST_LK0   = 22'h000100,
    ST_LK1   = 22'h000200,
    ST_LK2   = 22'h000400,
    ST_LK3   = 22'h000800,
    ST_LK4   = 22'h001000,
    ST_OUT   = 22'h002000,
    ST_CA0   = 22'h004000,
    ST_TADV  = 22'h008000,
    ST_DR1   = 22'h010000,
    ST_WK0   = 22'h020000,
    ST_WK1   = 22'h040000,
    ST_EX    = 22'h080000,
    ST_WK2   = 22'h100000,
    ST_CAEND = 22'h200000
  } state_t;

  state_t               state;
  logic [SLOT_W-1:0]    clr;
  logic [OP_W-1:0]      opreg;
  logic [ID_W-1:0]      cur;
  logic [TICK_BITS-1:0] dl;
  logic [TICK_BITS-1:0] tick;
  logic [LEVEL0_BITS-1:0] l0hand;
  logic [UPPER_BITS-1:0] uhand [UPPER_LEVELS];
  logic [TIMER_COUNT-1:0] armed;
  logic [ID_W-1:0]      nx;
  logic [ID_W-1:0]      pv;
  logic [SLOT_W-1:0]    uslot;
  logic [SLOT_W-1:0]    lslot;
  logic [SLOT_W-1:0]    dslot;
  logic [ID_W-1:0]      hreg;
  logic [ID_W-1:0]      treg;
  logic [ID_W-1:0]      hsave;
  logic [ID_W-1:0]      nsave;
  logic [CNT_W-1:0]     cnt;
  logic [LIDX_W-1:0]    lidx;
  logic                 casc;

  logic [LIDX_W-1:0]    dstart;
  logic [SLOT_W-1:0]    cslot;
  logic                 head_empty;
  logic                 walk_end;
  logic                 id_ok;
  logic [ID_W-1:0]      in_idx;

  assign head_empty = (hrd >= EMPTY_LINK);
  assign walk_end   = (nsave == hsave) || (cnt == CNT_W'(TIMER_COUNT));
  assign id_ok      = (int'(in_id) < TIMER_COUNT);
  assign in_idx     = ID_W'(in_id);
  assign cslot      = SLOT_W'(L0_SIZE) + (SLOT_W'(lidx) << UPPER_BITS) + SLOT_W'(uhand[lidx]);
  assign in_ready   = (state == ST_IDLE);

  // Deepest level that cascades: each level below it has its hand at zero.
  always_comb begin
    logic stop;
    dstart = '0;
    stop   = 1'b0;
    for (int k = 0; k < UPPER_LEVELS - 1; k++) begin
      if (!stop && (uhand[k] == '0)) begin
        dstart = LIDX_W'(k + 1);
      end else begin
        stop = 1'b1;
      end
    end
  end

  always_comb begin
    entry_t tmp;
    tmp  = erd;
    hreq = '0;
    ereq = '0;
    emit = '0;
    case (state)
      ST_CLEAR: begin
        hreq.we    = 1'b1;
        hreq.waddr = clr;
        hreq.wdata = EMPTY_LINK;
      end
      ST_UL0: ereq.raddr = cur;
      ST_UL1: begin
        if (erd.nxt == cur) begin
          hreq.we    = 1'b1;
          hreq.waddr = erd.slot;
          hreq.wdata = EMPTY_LINK;
        end else begin
          hreq.raddr = erd.slot;
          ereq.raddr = erd.prv;
        end
      end
      ST_UL2: begin
        tmp.nxt    = nx;
        ereq.we    = 1'b1;
        ereq.waddr = pv;
        ereq.wdata = tmp;
        if (hrd == LINK_W'(cur)) begin
          hreq.we    = 1'b1;
          hreq.waddr = uslot;
          hreq.wdata = LINK_W'(nx);
        end
      end
      ST_UL3: ereq.raddr = nx;
      ST_UL4: begin
        tmp.prv    = pv;
        ereq.we    = 1'b1;
        ereq.waddr = nx;
        ereq.wdata = tmp;
      end
      ST_LK0: hreq.raddr = lslot;
      ST_LK1: begin
        if (head_empty) begin
          hreq.we    = 1'b1;
          hreq.waddr = lslot;
          hreq.wdata = LINK_W'(cur);
          ereq.we    = 1'b1;
          ereq.waddr = cur;
          ereq.wdata = '{dl: dl, slot: lslot, prv: cur, nxt: cur};
        end else begin
          ereq.raddr = ID_W'(hrd);
        end
      end
      ST_LK2: begin
        // A single-entry list has its head as its own tail.
        if (erd.prv == hreg) begin
          tmp.nxt = cur;
        end
        tmp.prv    = cur;
        ereq.we    = 1'b1;
        ereq.waddr = hreg;
        ereq.wdata = tmp;
      end
      ST_LK3: begin
        ereq.we    = 1'b1;
        ereq.waddr = cur;
        ereq.wdata = '{dl: dl, slot: lslot, prv: treg, nxt: hreg};
        ereq.raddr = treg;
      end
      ST_LK4: begin
        tmp.nxt    = cur;
        ereq.we    = 1'b1;
        ereq.waddr = treg;
        ereq.wdata = tmp;
      end
      ST_OUT: begin
        emit.valid = 1'b1;
        emit.id    = cur;
        emit.cause = CAUSE_CANCELLED;
        emit.last  = 1'b1;
      end
      ST_CA0:  hreq.raddr = cslot;
      ST_TADV: hreq.raddr = SLOT_W'(l0hand);
      ST_DR1: begin
        if (!head_empty) begin
          hreq.we    = 1'b1;
          hreq.waddr = dslot;
          hreq.wdata = EMPTY_LINK;
        end
      end
      ST_WK0: ereq.raddr = cur;
      ST_EX: begin
        emit.valid = 1'b1;
        emit.id    = cur;
        emit.cause = CAUSE_EXPIRED;
        emit.last  = walk_end;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      clr    <= '0;
      tick   <= '0;
      l0hand <= '0;
      armed  <= '0;
      casc   <= 1'b0;
      for (int k = 0; k < UPPER_LEVELS; k++) begin
        uhand[k] <= '0;
      end
    end else begin
      case (state)
        ST_CLEAR: begin
          clr <= clr + SLOT_W'(1);
          if (clr == SLOT_W'(SLOT_TOTAL - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            opreg <= in_op;
            cur   <= in_idx;
            dl    <= TICK_BITS'(in_dl);
            case (in_op)
              OP_ARM: begin
                if (id_ok) begin
                  armed[in_idx] <= 1'b1;
                  state <= armed[in_idx] ? ST_UL0 : ST_FILE;
                end
              end
              OP_CANCEL: begin
                if (id_ok && armed[in_idx]) begin
                  state <= ST_UL0;
                end
              end
              OP_TICK: begin
                casc <= 1'b1;
                lidx <= dstart;
                state <= (l0hand == '0) ? ST_CA0 : ST_TADV;
              end
              default: begin
              end
            endcase
          end
        end
        ST_UL0: state <= ST_UL1;
        ST_UL1: begin
          nx    <= erd.nxt;
          pv    <= erd.prv;
          uslot <= erd.slot;
          if (erd.nxt == cur) begin
            if (opreg == OP_ARM) begin
              state <= ST_FILE;
            end else begin
              armed[cur] <= 1'b0;
              state <= ST_OUT;
            end
          end else begin
            state <= ST_UL2;
          end
        end
        ST_UL2: state <= ST_UL3;
        ST_UL3: state <= ST_UL4;
        ST_UL4: begin
          if (opreg == OP_ARM) begin
            state <= ST_FILE;
          end else begin
            armed[cur] <= 1'b0;
            state <= ST_OUT;
          end
        end
        ST_FILE: begin
          lslot <= file_slot(dl, tick);
          state <= ST_LK0;
        end
        ST_LK0: state <= ST_LK1;
        ST_LK1: begin
          hreg <= ID_W'(hrd);
          if (head_empty) begin
            state <= (opreg == OP_ARM) ? ST_IDLE : ST_WK2;
          end else begin
            state <= ST_LK2;
          end
        end
        ST_LK2: begin
          treg  <= erd.prv;
          state <= ST_LK3;
        end
        ST_LK3: begin
          if (treg == hreg) begin
            state <= (opreg == OP_ARM) ? ST_IDLE : ST_WK2;
          end else begin
            state <= ST_LK4;
          end
        end
        ST_LK4: state <= (opreg == OP_ARM) ? ST_IDLE : ST_WK2;
        ST_OUT: begin
          if (emit_ok) begin
            state <= ST_IDLE;
          end
        end
        ST_CA0: begin
          dslot <= cslot;
          state <= ST_DR1;
        end
        ST_TADV: begin
          tick   <= tick + TICK_BITS'(1);
          l0hand <= l0hand + LEVEL0_BITS'(1);
          dslot  <= SLOT_W'(l0hand);
          casc   <= 1'b0;
          state  <= ST_DR1;
        end
        ST_DR1: begin
          hsave <= ID_W'(hrd);
          cur   <= ID_W'(hrd);
          cnt   <= '0;
          if (head_empty) begin
            state <= casc ? ST_CAEND : ST_IDLE;
          end else begin
            state <= ST_WK0;
          end
        end
        ST_WK0: state <= ST_WK1;
        ST_WK1: begin
          nsave <= erd.nxt;
          dl    <= erd.dl;
          cnt   <= cnt + CNT_W'(1);
          state <= casc ? ST_FILE : ST_EX;
        end
        ST_EX: begin
          if (emit_ok) begin
            armed[cur] <= 1'b0;
            state <= ST_WK2;
          end
        end
        ST_WK2: begin
          if (!walk_end) begin
            cur   <= nsave;
            state <= ST_WK0;
          end else begin
            state <= casc ? ST_CAEND : ST_IDLE;
          end
        end
        ST_CAEND: begin
          uhand[lidx] <= uhand[lidx] + UPPER_BITS'(1);
          if (lidx == '0) begin
            state <= ST_TADV;
          end else begin
            lidx  <= lidx - LIDX_W'(1);
            state <= ST_CA0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/hierarchical_timer_wheel.sv
// Top level of the hierarchical timer wheel: stream ports, memories and result register.
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tuser: operation; tdata: timer_id, deadline
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata: woken_id; tuser: cause; tlast: last
//
// After reset the block sweeps all 512 slot heads to empty, one per cycle, and holds
// s_axis_tready low for the whole sweep.
// One request is taken at a time; s_axis_tready is high only while the sequencer is idle.
// A re-arm first unlinks the timer from its old slot; a cancel of an armed timer unlinks
// it and then hands over its result. A tick walks each cascading level and refiles each
// timer moved down, then hands over each timer that expires. Every list step goes through
// a registered read of the slot or entry memory.
// A stalled result port holds the sequencer only when it has a new result to hand over.
module hierarchical_timer_wheel import htw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [5:0] timer_id, [37:6] deadline, rest zero
  input  logic [OP_W-1:0]        s_axis_tuser,   // [1:0] operation
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [5:0] woken_id, rest zero
  output logic [0:0]             m_axis_tuser,   // [0] cause
  output logic                   m_axis_tlast    // last result of the request
);

  head_req_t       hreq;
  ent_req_t        ereq;
  logic [LINK_W-1:0] hrd;
  logic [$bits(entry_t)-1:0] erd_raw;
  emit_t           emit;
  logic            emit_ok;

  logic            out_valid;
  logic [ID_W-1:0] out_id;
  logic            out_cause;
  logic            out_last;

  // Slot heads: one link per slot, the first timer of its list or the empty mark.
  htw_ram #(.WIDTH(LINK_W), .DEPTH(SLOT_TOTAL)) u_heads (
    .clk   (clk),
    .we    (hreq.we),
    .waddr (hreq.waddr),
    .wdata (hreq.wdata),
    .raddr (hreq.raddr),
    .rdata (hrd)
  );

  // Per-timer record: list links, slot and deadline.
  htw_ram #(.WIDTH($bits(entry_t)), .DEPTH(TIMER_COUNT)) u_entries (
    .clk   (clk),
    .we    (ereq.we),
    .waddr (ereq.waddr),
    .wdata (ereq.wdata),
    .raddr (ereq.raddr),
    .rdata (erd_raw)
  );

  htw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tuser),
    .in_id    (s_axis_tdata[TIMER_ID_W-1:0]),
    .in_dl    (s_axis_tdata[TIMER_ID_W +: DEADLINE_W]),
    .hreq     (hreq),
    .hrd      (hrd),
    .ereq     (ereq),
    .erd      (entry_t'(erd_raw)),
    .emit     (emit),
    .emit_ok  (emit_ok)
  );

  // The result register takes a new result whenever it is empty or being drained.
  assign emit_ok = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid && emit_ok) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid && emit_ok) begin
      out_id    <= emit.id;
      out_cause <= emit.cause;
      out_last  <= emit.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(WOKEN_W'(out_id));
  assign m_axis_tuser  = out_cause;
  assign m_axis_tlast  = out_last;

endmodule

>>> hw/rtl/htw_checker.sv
// Port-level checks of the hierarchical timer wheel, bound to its top level.
module htw_checker import htw_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [OP_W-1:0]        s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]             m_axis_tuser,
  input logic                   m_axis_tlast
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // The slot sweep after reset keeps the input closed.
  a_reset_sweep: assert property (@(posedge clk) $fell(rst) |-> !s_axis_tready)
    else $error("request taken during slot sweep");

  // An arm or a tick always keeps the sequencer busy for the cycle after it is taken.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready &&
      (s_axis_tuser == OP_ARM || s_axis_tuser == OP_TICK) |=> !s_axis_tready)
    else $error("second request taken back to back");

  // A cancel gives at most one result, so it is always the last one.
  a_cancel_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[0] == CAUSE_EXPIRED) || m_axis_tlast)
    else $error("cancel result without last mark");

endmodule

bind hierarchical_timer_wheel htw_checker u_checker (.*);

>>> test/htw_checker.sv
// Checker for the hierarchical timer wheel: watches both streams, predicts results, compares.
module htw_monitor import htw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [OP_W-1:0]        s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [0:0]             m_axis_tuser,
  input  logic                   m_axis_tlast,
  output int                     failures,
  output int                     pending
);

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            cause;
    logic            last;
  } wake_t;

  wake_t wake_q[$];

  logic [TICK_BITS-1:0]   now_tick;
  logic [LEVEL0_BITS-1:0] wheel_hand;
  logic [UPPER_BITS-1:0]  level_hand[UPPER_LEVELS];
  int                     head_of[SLOT_TOTAL];
  int                     nxt_of[TIMER_COUNT];
  int                     prv_of[TIMER_COUNT];
  logic [TICK_BITS-1:0]   due_of[TIMER_COUNT];
  int                     slot_of[TIMER_COUNT];
  logic                   armed[TIMER_COUNT];

  assign pending = wake_q.size();

  function automatic void clear_wheel();
    now_tick = '0;
    wheel_hand = '0;
    for (int i = 0; i < UPPER_LEVELS; i++) level_hand[i] = '0;
    for (int i = 0; i < SLOT_TOTAL; i++) head_of[i] = TIMER_COUNT;
    for (int i = 0; i < TIMER_COUNT; i++) begin
      armed[i] = 1'b0;
      nxt_of[i] = 0;
      prv_of[i] = 0;
      due_of[i] = '0;
      slot_of[i] = 0;
    end
  endfunction

  function automatic void queue_wake(int id, logic cause, logic last);
    wake_t w;
    w.id = ID_W'(id);
    w.cause = cause;
    w.last = last;
    wake_q = {wake_q, w};
  endfunction

  function automatic void append(int id, int slot);
    int head;
    int tail;
    head = head_of[slot];
    slot_of[id] = slot;
    if (head >= TIMER_COUNT) begin
      head_of[slot] = id;
      nxt_of[id] = id;
      prv_of[id] = id;
    end else begin
      tail = prv_of[head];
      nxt_of[tail] = id;
      prv_of[id] = tail;
      nxt_of[id] = head;
      prv_of[head] = id;
    end
  endfunction

  function automatic void detach(int id);
    int slot;
    int nx;
    int pv;
    slot = slot_of[id];
    nx = nxt_of[id];
    pv = prv_of[id];
    if (nx == id) head_of[slot] = TIMER_COUNT;
    else begin
      nxt_of[pv] = nx;
      prv_of[nx] = pv;
      if (head_of[slot] == id) head_of[slot] = nx;
    end
  endfunction

  // Level by distance to the (clamped) deadline, slot by the matching deadline bits.
  function automatic void place(int id);
    logic [TICK_BITS-1:0] due;
    logic [TICK_BITS-1:0] span;
    int lvl;
    int sh;
    due = (due_of[id] > now_tick) ? due_of[id] : now_tick;
    span = due - now_tick;
    lvl = UPPER_LEVELS;
    for (int k = UPPER_LEVELS - 1; k >= 0; k--) begin
      sh = LEVEL0_BITS + k * UPPER_BITS;
      if (sh >= TICK_BITS || (span >> sh) == 0) lvl = k;
    end
    if (lvl == 0) append(id, int'(due[LEVEL0_BITS-1:0]));
    else begin
      sh = LEVEL0_BITS + (lvl - 1) * UPPER_BITS;
      append(id, L0_SIZE + (lvl - 1) * UP_SIZE +
                 int'((due >> sh) & TICK_BITS'(UP_SIZE - 1)));
    end
  endfunction

  function automatic int drain_slot(int slot, ref int ids[TIMER_COUNT]);
    int n;
    int head;
    int cur;
    n = 0;
    head = head_of[slot];
    if (head >= TIMER_COUNT) return 0;
    cur = head;
    do begin
      ids[n] = cur;
      n++;
      cur = nxt_of[cur];
    end while (cur != head && n < TIMER_COUNT);
    head_of[slot] = TIMER_COUNT;
    return n;
  endfunction

  function automatic void cascade_from(int lvl);
    int ids[TIMER_COUNT];
    int n;
    int hand;
    for (int l = lvl; l <= UPPER_LEVELS; l++) begin
      if (level_hand[l-1] != 0) begin
        // Deepest wrapped level found; cascade upward-first order from here down.
        for (int m = l; m >= lvl; m--) begin
          hand = int'(level_hand[m-1]);
          n = drain_slot(L0_SIZE + (m - 1) * UP_SIZE + hand, ids);
          for (int k = 0; k < n; k++) place(ids[k]);
          level_hand[m-1] = UPPER_BITS'(hand + 1);
        end
        return;
      end
    end
    for (int m = UPPER_LEVELS; m >= lvl; m--) begin
      hand = int'(level_hand[m-1]);
      n = drain_slot(L0_SIZE + (m - 1) * UP_SIZE + hand, ids);
      for (int k = 0; k < n; k++) place(ids[k]);
      level_hand[m-1] = UPPER_BITS'(hand + 1);
    end
  endfunction

  function automatic void predict_request(logic [OP_W-1:0] op, int id, logic [31:0] due);
    int ids[TIMER_COUNT];
    int n;
    int hand;
    case (op)
      OP_ARM: begin
        if (armed[id]) detach(id);
        due_of[id] = due;
        armed[id] = 1'b1;
        place(id);
      end
      OP_CANCEL: begin
        if (armed[id]) begin
          detach(id);
          armed[id] = 1'b0;
          queue_wake(id, CAUSE_CANCELLED, 1'b1);
        end
      end
      OP_TICK: begin
        hand = int'(wheel_hand);
        if (hand == 0) cascade_from(1);
        now_tick = now_tick + TICK_BITS'(1);
        n = drain_slot(hand, ids);
        for (int k = 0; k < n; k++) begin
          armed[ids[k]] = 1'b0;
          queue_wake(ids[k], CAUSE_EXPIRED, (k + 1 == n));
        end
        wheel_hand = LEVEL0_BITS'(hand + 1);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    wake_t got;
    wake_t want;
    if (rst) begin
      clear_wheel();
      wake_q.delete();
      failures <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{id: m_axis_tdata[5:0], cause: m_axis_tuser[0], last: m_axis_tlast};
        if (wake_q.size() == 0) begin
          if (failures < 10) $display("unexpected result id=%0d cause=%0d last=%0d",
                                      got.id, got.cause, got.last);
          failures <= failures + 1;
        end else begin
          want = wake_q.pop_front();
          if (got != want || m_axis_tdata[7:6] != 2'b00) begin
            if (failures < 10)
              $display("mismatch: expected id=%0d cause=%0d last=%0d, got id=%0d cause=%0d last=%0d",
                       want.id, want.cause, want.last, got.id, got.cause, got.last);
            failures <= failures + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_request(s_axis_tuser, int'(s_axis_tdata[5:0]), s_axis_tdata[37:6]);
    end
  end

endmodule

>>> test/testbench.sv
// Top of the timer wheel testbench: clock, reset, request stimulus and verdict.
module testbench;
  import htw_pkg::*;

  // Operation code the block ignores.
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   m_axis_tlast;
  int                     failures;
  int                     pending;
  int                     hold_off;
  logic                   hold_used;
  logic                   want_hold;

  // Mirror of the current tick so that random deadlines land near it.
  logic [31:0] tick_seen;

  hierarchical_timer_wheel dut (.*);
  htw_monitor checker_i (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_request(logic [OP_W-1:0] op, logic [5:0] id, logic [31:0] due);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, due, id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op == OP_TICK) tick_seen = tick_seen + 32'd1;
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Deadline mostly near now so timers fire, sometimes at far levels or in the past.
  function automatic logic [31:0] pick_deadline();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return tick_seen - $urandom_range(0, 50);
      2:       return tick_seen + $urandom_range(256, 20000);
      default: return tick_seen + $urandom_range(0, 40);
    endcase
  endfunction

  // The receiver stalls on its own pattern; one long hold-off fills the block.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_off <= 0;
      hold_used <= 1'b0;
    end else if (want_hold && !hold_used) begin
      m_axis_tready <= 1'b0;
      hold_off <= 300;
      hold_used <= 1'b1;
    end else if (hold_off > 0) begin
      m_axis_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int burst;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_ARM;
    want_hold = 1'b0;
    tick_seen = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, re-arm, idle cancel, past clamp, far level, ignored operation.
    send_request(OP_ARM, 6'd0, 32'd0);
    send_request(OP_ARM, 6'd63, 32'hFFFF_FFFF);
    send_request(OP_ARM, 6'd1, 32'd3);
    send_request(OP_ARM, 6'd2, 32'd3);
    send_request(OP_ARM, 6'd3, 32'd300);
    send_request(OP_ARM, 6'd4, 32'd70000);
    send_request(OP_ARM, 6'd5, 32'h00AA_5555);
    send_request(OP_ARM, 6'd2, 32'd2);
    send_request(OP_CANCEL, 6'd10, 32'h5555_AAAA);
    send_request(OP_IGNORED, 6'h2A, 32'hFFFF_FFFF);
    send_request(OP_TICK, 6'd0, 32'd0);
    send_request(OP_TICK, 6'd0, 32'd0);
    send_request(OP_TICK, 6'd0, 32'd0);
    send_request(OP_TICK, 6'd0, 32'd0);
    send_request(OP_CANCEL, 6'd63, 32'd0);
    send_request(OP_CANCEL, 6'd4, 32'd0);
    send_request(OP_CANCEL, 6'd5, 32'd0);

    // Long hold-off while many timers share one slot and then expire together.
    want_hold = 1'b1;
    for (int i = 0; i < 12; i++) send_request(OP_ARM, 6'(i + 20), tick_seen + 32'd2);
    send_request(OP_TICK, 6'd0, 32'd0);
    send_request(OP_TICK, 6'd0, 32'd0);
    send_request(OP_TICK, 6'd0, 32'd0);

    // Random part: arms, cancels of armed and idle timers, ticks and ignored operations.
    for (int n = 0; n < 175; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && n < 175; b++, n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: send_request(OP_ARM, 6'($urandom()), pick_deadline());
          3:       send_request(OP_CANCEL, 6'($urandom()), $urandom());
          9:       send_request(OP_IGNORED, 6'($urandom()), $urandom());
          default: send_request(OP_TICK, 6'($urandom()), $urandom());
        endcase
      end
      idle_gap();
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (failures == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
